/* rtl/lex_pkg.sv */
package lex_pkg;

  // Result field widths
  localparam int unsigned TypeW  = 4;
  localparam int unsigned StartW = 10;
  localparam int unsigned LenW   = 8;
  localparam int unsigned ByteW  = 8;

  // Default limits
  localparam int unsigned MAX_TOKEN_LEN_DEF = 128;
  localparam int unsigned TEXT_LIMIT_DEF    = 1024;

  // Result queue between scanner and output side
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Token type codes
  localparam logic [TypeW-1:0] TOK_NUMBER = 4'd0;
  localparam logic [TypeW-1:0] TOK_IDENT  = 4'd1;
  localparam logic [TypeW-1:0] TOK_ASSIGN = 4'd2;
  localparam logic [TypeW-1:0] TOK_PLUS   = 4'd3;
  localparam logic [TypeW-1:0] TOK_MINUS  = 4'd4;
  localparam logic [TypeW-1:0] TOK_MUL    = 4'd5;
  localparam logic [TypeW-1:0] TOK_DIV    = 4'd6;
  localparam logic [TypeW-1:0] TOK_LPAREN = 4'd7;
  localparam logic [TypeW-1:0] TOK_RPAREN = 4'd8;
  localparam logic [TypeW-1:0] TOK_END    = 4'd9;

  // Character constants
  localparam logic [ByteW-1:0] CH_DOT    = 8'h2E;
  localparam logic [ByteW-1:0] CH_UNDER  = 8'h5F;
  localparam logic [ByteW-1:0] CH_ASSIGN = 8'h3D;
  localparam logic [ByteW-1:0] CH_PLUS   = 8'h2B;
  localparam logic [ByteW-1:0] CH_MINUS  = 8'h2D;
  localparam logic [ByteW-1:0] CH_STAR   = 8'h2A;
  localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ByteW-1:0] CH_LPAREN = 8'h28;
  localparam logic [ByteW-1:0] CH_RPAREN = 8'h29;

  // One result word
  typedef struct packed {
    logic [TypeW-1:0]  tok_type;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic              bad;
    logic [ByteW-1:0]  bad_byte;
    logic              last;
  } lex_result_t;

  // Words pushed by the scanner in one cycle
  typedef struct packed {
    logic [1:0]  num;
    lex_result_t r0;
    lex_result_t r1;
  } lex_push_t;

endpackage

/* rtl/expression_lexer.sv */
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_ready_o   character_i, end_of_text_i
// out      output     out_valid_o / out_ready_i token_type_o .. last_of_run_o
//
// One character is taken per cycle while in_ready_o is high; each gives
// zero to two words. The queue drains one word per cycle while out_ready_i
// is high, so one result per character keeps pace; two per character do not.
// in_ready_o falls only when the four-word queue has room for fewer than two.
// Reset clears the scanner state and empties the queue; no clearing pass.
module expression_lexer #(
  parameter int unsigned MAX_TOKEN_LEN = lex_pkg::MAX_TOKEN_LEN_DEF,
  parameter int unsigned TEXT_LIMIT    = lex_pkg::TEXT_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lex_pkg::ByteW-1:0]   character_i,
  input  logic                        end_of_text_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [lex_pkg::TypeW-1:0]   token_type_o,
  output logic [lex_pkg::StartW-1:0]  token_start_o,
  output logic [lex_pkg::LenW-1:0]    token_length_o,
  output logic                        bad_character_o,
  output logic [lex_pkg::ByteW-1:0]   offending_byte_o,
  output logic                        last_of_run_o
);
  import lex_pkg::*;

  logic        accept;
  lex_push_t   push;
  lex_result_t head;

  assign accept = in_valid_i && in_ready_o;

  lex_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .TEXT_LIMIT    (TEXT_LIMIT)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .character_i   (character_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push)
  );

  lex_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  // Unpack the head word onto the ports
  assign token_type_o     = head.tok_type;
  assign token_start_o    = head.start;
  assign token_length_o   = head.len;
  assign bad_character_o  = head.bad;
  assign offending_byte_o = head.bad_byte;
  assign last_of_run_o    = head.last;

endmodule

/* rtl/lex_scan.sv */
module lex_scan #(
  parameter int unsigned MAX_TOKEN_LEN = lex_pkg::MAX_TOKEN_LEN_DEF,
  parameter int unsigned TEXT_LIMIT    = lex_pkg::TEXT_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [lex_pkg::ByteW-1:0]    character_i,
  input  logic                         end_of_text_i,
  output lex_pkg::lex_push_t           push_o
);
  import lex_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned PosW = $clog2(TEXT_LIMIT);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TOKEN_LEN);
  localparam logic [PosW-1:0] PosMax = PosW'(TEXT_LIMIT - 1);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_IDENT  = 2'd2;
  localparam logic [1:0] MODE_HALTED = 2'd3;

  logic [1:0]      mode_q, mode_d, mode_mid;
  logic [PosW-1:0] begin_q, begin_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d, pos_inc;
  logic            is_dig, is_let, is_blank, is_tok, cont, flush;
  logic [TypeW-1:0] op_type;
  logic            is_op;
  lex_result_t     emit;
  logic            do_emit;

  // Classify the incoming character
  always_comb begin
    is_dig   = character_i inside {[8'h30:8'h39]};
    is_let   = character_i inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_blank = character_i inside {8'h20, [8'h09:8'h0D]};
    is_op    = 1'b1;
    case (character_i)
      CH_ASSIGN: op_type = TOK_ASSIGN;
      CH_PLUS:   op_type = TOK_PLUS;
      CH_MINUS:  op_type = TOK_MINUS;
      CH_STAR:   op_type = TOK_MUL;
      CH_SLASH:  op_type = TOK_DIV;
      CH_LPAREN: op_type = TOK_LPAREN;
      CH_RPAREN: op_type = TOK_RPAREN;
      default: begin
        op_type = TOK_NUMBER;
        is_op   = 1'b0;
      end
    endcase
  end

  assign pos_inc = (pos_q < PosMax) ? pos_q + 1'b1 : pos_q;

  // Work out the mode update and the words of this character
  always_comb begin
    mode_d   = mode_q;
    begin_d  = begin_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    mode_mid = mode_q;
    flush    = 1'b0;
    do_emit  = 1'b0;
    emit     = '0;
    push_o   = '0;
    is_tok   = (mode_q == MODE_NUMBER) || (mode_q == MODE_IDENT);
    if (mode_q == MODE_NUMBER) begin
      cont = !end_of_text_i && (is_dig || character_i == CH_DOT);
    end else begin
      cont = !end_of_text_i && (is_let || is_dig || character_i == CH_UNDER);
    end

    if (is_tok && cont) begin
      // extend the pending token
      if (cnt_q < CntMax) cnt_d = cnt_q + 1'b1;
      pos_d = pos_inc;
    end else begin
      if (is_tok) begin
        // close the pending token
        flush              = 1'b1;
        push_o.r0.tok_type = (mode_q == MODE_NUMBER) ? TOK_NUMBER : TOK_IDENT;
        push_o.r0.start    = StartW'(begin_q);
        push_o.r0.len      = LenW'(cnt_q);
        mode_mid           = MODE_IDLE;
        mode_d             = MODE_IDLE;
        cnt_d              = '0;
      end
      if (end_of_text_i) begin
        do_emit        = 1'b1;
        emit.tok_type  = TOK_END;
        emit.start     = StartW'(pos_q);
        mode_d         = MODE_IDLE;
        begin_d        = '0;
        cnt_d          = '0;
        pos_d          = '0;
      end else if (mode_mid != MODE_HALTED) begin
        if (is_blank) begin
          pos_d = pos_inc;
        end else if (is_dig) begin
          mode_d  = MODE_NUMBER;
          begin_d = pos_q;
          cnt_d   = CntW'(1);
          pos_d   = pos_inc;
        end else if (is_let || character_i == CH_UNDER) begin
          mode_d  = MODE_IDENT;
          begin_d = pos_q;
          cnt_d   = CntW'(1);
          pos_d   = pos_inc;
        end else if (is_op) begin
          do_emit       = 1'b1;
          emit.tok_type = op_type;
          emit.start    = StartW'(pos_q);
          emit.len      = LenW'(1);
          pos_d         = pos_inc;
        end else begin
          // illegal character: report and halt
          do_emit       = 1'b1;
          emit.tok_type = TOK_NUMBER;
          emit.start    = StartW'(pos_q);
          emit.bad      = 1'b1;
          emit.bad_byte = character_i;
          mode_d        = MODE_HALTED;
        end
      end
    end

    // Place the words and mark the final one
    if (flush && do_emit) begin
      push_o.num     = 2'd2;
      push_o.r1      = emit;
      push_o.r1.last = 1'b1;
    end else if (flush) begin
      push_o.num     = 2'd1;
      push_o.r0.last = 1'b1;
    end else if (do_emit) begin
      push_o.num     = 2'd1;
      push_o.r0      = emit;
      push_o.r0.last = 1'b1;
    end
    if (!accept_i) push_o.num = 2'd0;
  end

  // Hold the scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      begin_q <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* rtl/lex_queue.sv */
module lex_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lex_pkg::lex_push_t    push_i,
  output logic                  space_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lex_pkg::lex_result_t  head_o
);
  import lex_pkg::*;

  lex_result_t      mem_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  // room for the largest burst of one character
  assign space_o     = (cnt_q <= QCntW'(QDepth - 2));

  // Write up to two words
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.num == 2'd2) mem_q[wr_q + 1'b1] <= push_i.r1;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QAw'(push_i.num);
      rd_q  <= rd_q + QAw'(pop);
      cnt_q <= cnt_q + QCntW'(push_i.num) - QCntW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> space_o)
    else $error("queue written without room");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue occupancy out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd2 && !pop) |=> cnt_q == $past(cnt_q) + QCntW'(2))
    else $error("occupancy lost a double push");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != QCntW'(QDepth)) |-> (QAw'(wr_q - rd_q) == QAw'(cnt_q)))
    else $error("pointers disagree with occupancy");
`endif

endmodule

/* dv/tb_expression_lexer.sv */
`timescale 1ns / 1ps

module tb_expression_lexer;
  import lex_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned HoldCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ByteW-1:0] character_i = '0;
  logic end_of_text_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [TypeW-1:0] token_type_o;
  logic [StartW-1:0] token_start_o;
  logic [LenW-1:0] token_length_o;
  logic bad_character_o;
  logic [ByteW-1:0] offending_byte_o;
  logic last_of_run_o;

  // Token predictor and the queue of token words still owed by the block
  class lex_board;
    typedef enum logic [1:0] {
      SCAN_IDLE, SCAN_NUMBER, SCAN_IDENT, SCAN_HALTED
    } scan_mode_e;

    scan_mode_e mode = SCAN_IDLE;
    logic [StartW-1:0] tok_begin = '0;
    logic [LenW-1:0] tok_len = '0;
    logic [StartW-1:0] pos = '0;
    lex_result_t expected_q[$];
    int failures = 0;
    int words_checked = 0;
    int live_words = 0;
    int halted_words = 0;
    int error_reports = 0;
    int capped_tokens = 0;
    bit pos_capped = 1'b0;

    function bit is_digit(logic [ByteW-1:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(logic [ByteW-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_blank(logic [ByteW-1:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // The number code doubles as "not an operator"
    function logic [TypeW-1:0] op_code(logic [ByteW-1:0] c);
      case (c)
        CH_ASSIGN: return TOK_ASSIGN;
        CH_PLUS:   return TOK_PLUS;
        CH_MINUS:  return TOK_MINUS;
        CH_STAR:   return TOK_MUL;
        CH_SLASH:  return TOK_DIV;
        CH_LPAREN: return TOK_LPAREN;
        CH_RPAREN: return TOK_RPAREN;
        default:   return TOK_NUMBER;
      endcase
    endfunction

    function bit opens_cleanly(logic [ByteW-1:0] c);
      return is_blank(c) || is_digit(c) || is_letter(c) || c == CH_UNDER ||
             op_code(c) != TOK_NUMBER;
    endfunction

    function void push_token(logic [TypeW-1:0] ty, logic [StartW-1:0] st,
                             logic [LenW-1:0] ln, logic bad, logic [ByteW-1:0] b);
      lex_result_t r;
      r.tok_type = ty;
      r.start = st;
      r.len = ln;
      r.bad = bad;
      r.bad_byte = b;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void advance_pos();
      if (pos < StartW'(TEXT_LIMIT_DEF - 1)) pos++;
      else pos_capped = 1'b1;
    endfunction

    function void begin_token(scan_mode_e m);
      mode = m;
      tok_begin = pos;
      tok_len = LenW'(1);
    endfunction

    // Predict the token words caused by one accepted input word
    function void note_word(logic [ByteW-1:0] c, logic eot);
      bit cont;
      bit halt_now;
      int n0;
      lex_result_t r;
      cont = 1'b0;
      halt_now = 1'b0;
      n0 = expected_q.size();
      if (mode == SCAN_HALTED && !eot) halted_words++;
      else live_words++;

      // Extend or close a pending number or identifier
      if (mode == SCAN_NUMBER || mode == SCAN_IDENT) begin
        if (!eot) begin
          if (mode == SCAN_NUMBER) cont = is_digit(c) || c == CH_DOT;
          else cont = is_letter(c) || is_digit(c) || c == CH_UNDER;
        end
        if (cont) begin
          if (tok_len < LenW'(MAX_TOKEN_LEN_DEF)) tok_len++;
          advance_pos();
          return;
        end
        push_token(mode == SCAN_NUMBER ? TOK_NUMBER : TOK_IDENT, tok_begin, tok_len,
                   1'b0, '0);
        if (tok_len == LenW'(MAX_TOKEN_LEN_DEF)) capped_tokens++;
        mode = SCAN_IDLE;
        tok_len = '0;
      end

      if (eot) begin
        push_token(TOK_END, pos, '0, 1'b0, '0);
        mode = SCAN_IDLE;
        tok_begin = '0;
        tok_len = '0;
        pos = '0;
      end else if (mode != SCAN_HALTED) begin
        if (is_blank(c)) begin
          // skip whitespace
        end else if (is_digit(c)) begin
          begin_token(SCAN_NUMBER);
        end else if (is_letter(c) || c == CH_UNDER) begin
          begin_token(SCAN_IDENT);
        end else if (op_code(c) != TOK_NUMBER) begin
          push_token(op_code(c), pos, LenW'(1), 1'b0, '0);
        end else begin
          // illegal byte: report it and stop scanning, position stays put
          push_token(TOK_NUMBER, pos, '0, 1'b1, c);
          mode = SCAN_HALTED;
          halt_now = 1'b1;
        end
        if (!halt_now) advance_pos();
      end

      // Flag the final word of this run
      if (expected_q.size() > n0) begin
        r = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Match one token word from the block against the oldest prediction
    function void check_result(lex_result_t got);
      lex_result_t want;
      if (expected_q.size() == 0) begin
        $error("token word with nothing pending: type %0d start %0d length %0d",
               got.tok_type, got.start, got.len);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      words_checked++;
      if (want.bad) error_reports++;
      compare_field("token_type", 16'(want.tok_type), 16'(got.tok_type));
      compare_field("token_start", 16'(want.start), 16'(got.start));
      compare_field("token_length", 16'(want.len), 16'(got.len));
      compare_field("bad_character", 16'(want.bad), 16'(got.bad));
      compare_field("offending_byte", 16'(want.bad_byte), 16'(got.bad_byte));
      compare_field("last_of_run", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  lex_board board = new;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned cycles = 0;
  lex_result_t seen;

  logic [ByteW-1:0] op_chars[7] = '{CH_ASSIGN, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                    CH_LPAREN, CH_RPAREN};
  int send_idle_by_phase[4] = '{0, 88, 0, 35};
  int recv_stall_by_phase[4] = '{0, 0, 88, 35};

  expression_lexer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .character_i     (character_i),
    .end_of_text_i   (end_of_text_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_type_o    (token_type_o),
    .token_start_o   (token_start_o),
    .token_length_o  (token_length_o),
    .bad_character_o (bad_character_o),
    .offending_byte_o(offending_byte_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #5ns clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check every token word the block hands over
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.tok_type = token_type_o;
      seen.start = token_start_o;
      seen.len = token_length_o;
      seen.bad = bad_character_o;
      seen.bad_byte = offending_byte_o;
      seen.last = last_of_run_o;
      board.check_result(seen);
    end
  end

  // Drive out_ready_i: random stalls, plus one long hold when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one word; called and returning at a falling edge
  task automatic send_word(input logic [ByteW-1:0] c, input logic eot);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    character_i <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(c, eot);
    @(negedge clk_i);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  function automatic logic [ByteW-1:0] pick_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [ByteW-1:0] pick_letter();
    return 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
  endfunction

  function automatic logic [ByteW-1:0] pick_blank();
    return ($urandom_range(5) == 0) ? 8'd32 : 8'(9 + $urandom_range(4));
  endfunction

  function automatic logic [ByteW-1:0] pick_illegal();
    logic [ByteW-1:0] c;
    do c = 8'($urandom_range(255)); while (board.opens_cleanly(c));
    return c;
  endfunction

  // Mostly short tokens, now and then one near or past the length cap
  function automatic int pick_len();
    return ($urandom_range(39) == 0) ? $urandom_range(140, 120) : $urandom_range(6, 1);
  endfunction

  // Send a text of n_tok tokens, optionally with an illegal byte, then end it
  task automatic send_expression(input int n_tok, input bit broken);
    int err_at;
    int len;
    err_at = broken ? $urandom_range(n_tok - 1) : -1;
    for (int k = 0; k < n_tok; k++) begin
      if (k == err_at) begin
        send_word(pick_illegal(), 1'b0);
        repeat ($urandom_range(3)) send_word(8'($urandom_range(255)), 1'b0);
      end
      case ($urandom_range(3))
        0: begin
          len = pick_len();
          send_word(pick_digit(), 1'b0);
          repeat (len - 1) send_word(($urandom_range(4) == 0) ? CH_DOT : pick_digit(), 1'b0);
        end
        1: begin
          len = pick_len();
          send_word(($urandom_range(4) == 0) ? CH_UNDER : pick_letter(), 1'b0);
          repeat (len - 1) begin
            case ($urandom_range(3))
              0: send_word(pick_digit(), 1'b0);
              1: send_word(CH_UNDER, 1'b0);
              default: send_word(pick_letter(), 1'b0);
            endcase
          end
        end
        2: send_word(op_chars[$urandom_range(6)], 1'b0);
        default: repeat ($urandom_range(3, 1)) send_word(pick_blank(), 1'b0);
      endcase
      if ($urandom_range(2) == 0) send_word(pick_blank(), 1'b0);
    end
    send_word(8'($urandom_range(255)), 1'b1);
  endtask

  initial begin
    int roll;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every operator and whitespace byte, adjacent tokens, flush on end
    send_string("_z 0.9+-*/()=");
    for (int w = 9; w <= 13; w++) send_word(8'(w), 1'b0);
    send_string("9Q");
    send_word(8'h00, 1'b1);
    // pending number flushed before an error, halted byte ignored
    send_string("7~x");
    send_word(8'hFF, 1'b1);
    // non-ASCII byte at the very start
    send_word(8'h80, 1'b0);
    send_word(8'h55, 1'b1);

    // Random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      if (ph == 0) begin
        // long text past the position cap while the receiver holds off
        hold_off = 1'b1;
        send_expression(280, 1'b0);
      end
      while (board.live_words + board.halted_words < 1250 + ph * 200) begin
        roll = $urandom_range(9);
        if (roll < 7) send_expression($urandom_range(12, 1), 1'b0);
        else if (roll < 9) send_expression($urandom_range(12, 1), 1'b1);
        else begin
          repeat ($urandom_range(20, 5))
            send_word(8'($urandom_range(255)), $urandom_range(9) == 0);
          send_word(8'($urandom_range(255)), 1'b1);
        end
      end
    end

    // Drain and let any stray word show up
    in_valid_i <= 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("lexer run: %0d words scanned, %0d ignored while halted, %0d token words checked",
             board.live_words, board.halted_words, board.words_checked);
    $display("  %0d illegal-byte reports, %0d tokens at the length cap, position cap %s",
             board.error_reports, board.capped_tokens,
             board.pos_capped ? "reached" : "not reached");
    if (board.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lex_pkg.sv
rtl/lex_scan.sv
rtl/lex_queue.sv
rtl/expression_lexer.sv
dv/tb_expression_lexer.sv
